// ===== rtl/core/kdpc_pkg.sv =====
// Package for the key debounce and press classifier.
// Holds event codes, register indexes, field widths and reset values.
// No dependencies.
package kdpc_pkg;

	// Time stamp width default
	localparam int TIME_BITS_DEF = 32;

	// Field widths
	localparam int TIME_IN_W = 32;
	localparam int THR_W     = 16;
	localparam int CONF_W    = 4;
	localparam int RUN_W     = 4;
	localparam int EVENT_W   = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	// Stream data widths, padded to whole bytes
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 8;

	// Press event codes
	localparam logic [EVENT_W-1:0] EV_IDLE  = 2'd0;
	localparam logic [EVENT_W-1:0] EV_SHORT = 2'd1;
	localparam logic [EVENT_W-1:0] EV_LONG  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LONG_THR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM  = 1'd1;

	// Register reset values
	localparam logic [THR_W-1:0]  THR_RESET     = 16'd1000;
	localparam logic [CONF_W-1:0] CONFIRM_RESET = 4'd3;

	// Saturation limit of the run counter
	localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;

	// Configuration handed to the core
	typedef struct packed {
		logic [THR_W-1:0]  long_press_threshold;
		logic [CONF_W-1:0] confirm_samples;
	} kdpc_cfg_t;

	// One key sample
	typedef struct packed {
		logic                 clear_event;
		logic [TIME_IN_W-1:0] time_now;
		logic                 raw_level;
	} kdpc_sample_t;

	// One result
	typedef struct packed {
		logic [EVENT_W-1:0] press_event;
		logic               debounced_level;
	} kdpc_result_t;

endpackage

// ===== rtl/core/key_debounce_press_classifier.sv =====
// Key debounce with short/long press classification, stream in and out.
// The result of an accepted sample is captured in the output register on the edge that accepts it.
// Throughput: 1 sample per cycle while m_tready is high; the output register frees as it is taken.
// Reset (arst_n low, asynchronous): state cleared, threshold 1000, confirm 3.
// Instantiates kdpc_core; uses kdpc_pkg.
module key_debounce_press_classifier import kdpc_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// sample stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // raw_level, time_now[32:1], clear_event, pad
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // debounced_level, press_event[2:1], pad
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data
);

	kdpc_cfg_t    cfg_q;
	kdpc_sample_t sample;
	kdpc_result_t result;
	logic         step;
	logic         out_valid_q;
	kdpc_result_t out_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_threshold <= THR_RESET;
			cfg_q.confirm_samples      <= CONFIRM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LONG_THR: cfg_q.long_press_threshold <= cfg_data;
				REG_CONFIRM:  cfg_q.confirm_samples      <= cfg_data[CONF_W-1:0];
				default: ;
			endcase
		end
	end

	// Accept while the output register is empty or being drained
	assign s_tready = !out_valid_q || m_tready;
	assign step     = s_tvalid && s_tready;
	assign sample   = s_tdata[$bits(kdpc_sample_t)-1:0];

	kdpc_core #(
		.TIME_BITS(TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.sample (sample),
		.cfg    (cfg_q),
		.result (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - $bits(kdpc_result_t)){1'b0}}, out_q};

endmodule

// ===== rtl/core/kdpc_core.sv =====
// Debounce state and press classification, one key sample per cycle while step is high.
// Holds the run counter, levels, press stamp and event. Uses kdpc_pkg.
module kdpc_core import kdpc_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  kdpc_sample_t sample,
	input  kdpc_cfg_t    cfg,
	output kdpc_result_t result
);

	logic                 prev_raw_q;
	logic [RUN_W-1:0]     run_q;
	logic                 conf_level_q;
	logic [TIME_BITS-1:0] stamp_q;
	logic [EVENT_W-1:0]   event_q;

	logic                 prev_raw_d;
	logic [RUN_W-1:0]     run_d;
	logic [RUN_W-1:0]     run_inc;
	logic                 conf_level_d;
	logic [TIME_BITS-1:0] stamp_d;
	logic [EVENT_W-1:0]   event_d;
	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] hold;
	logic                 is_long;
	logic                 confirm;

	// Input time taken modulo the stamp width
	assign now     = TIME_BITS'(sample.time_now);
	assign hold    = now - stamp_q;
	assign is_long = hold >= TIME_BITS'(cfg.long_press_threshold);

	// Saturating run count on a repeated sample
	assign run_inc = (run_q < cfg.confirm_samples && run_q != RUN_MAX) ?
		run_q + RUN_W'(1) : run_q;
	assign confirm = (run_inc >= cfg.confirm_samples) &&
		(sample.raw_level != conf_level_q);

	// Next state
	always_comb begin
		prev_raw_d   = prev_raw_q;
		run_d        = run_q;
		conf_level_d = conf_level_q;
		stamp_d      = stamp_q;
		event_d      = sample.clear_event ? EV_IDLE : event_q;
		if (sample.raw_level != prev_raw_q) begin
			prev_raw_d = sample.raw_level;
			run_d      = RUN_W'(1);
		end else begin
			run_d = run_inc;
			if (confirm) begin
				conf_level_d = sample.raw_level;
				if (sample.raw_level) begin
					stamp_d = now;
					event_d = EV_IDLE;
				end else if (!is_long) begin
					event_d = EV_SHORT;
				end
			end
			// Held press: a press confirmed on this sample has zero hold time
			if (sample.raw_level && (conf_level_q || confirm)) begin
				if (confirm ? (cfg.long_press_threshold == '0) : is_long) begin
					event_d = EV_LONG;
				end
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q   <= 1'b0;
			run_q        <= '0;
			conf_level_q <= 1'b0;
			stamp_q      <= '0;
			event_q      <= EV_IDLE;
		end else if (step) begin
			prev_raw_q   <= prev_raw_d;
			run_q        <= run_d;
			conf_level_q <= conf_level_d;
			stamp_q      <= stamp_d;
			event_q      <= event_d;
		end
	end

	assign result.debounced_level = conf_level_d;
	assign result.press_event     = event_d;

endmodule

// ===== sim/tb_key_debounce_press_classifier.sv =====
// Testbench for key_debounce_press_classifier: directed press/release cases, then random
// debounce traffic under several threshold and confirm settings, checked item by item.
// Depends on kdpc_pkg and the RTL of key_debounce_press_classifier.
module tb_key_debounce_press_classifier;
	import kdpc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Expected debounced level and press event for one sample
	typedef struct packed {
		logic               level;
		logic [EVENT_W-1:0] ev;
	} key_state_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;  // raw_level, time_now[32:1], clear_event, pad
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // debounced_level, press_event[2:1], pad
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DAT_W-1:0]  cfg_data  = '0;

	// Predictor state and its copy of the registers
	logic                 key_prev;
	logic [RUN_W-1:0]     key_run;
	logic                 key_level;
	logic [TIME_IN_W-1:0] key_stamp;
	logic [EVENT_W-1:0]   key_event;
	logic [THR_W-1:0]     cfg_thr;
	logic [CONF_W-1:0]    cfg_confirm;

	key_state_t           key_state_q[$];
	logic [TIME_IN_W-1:0] clk_ms;
	bit                   stalls_on = 1'b1;
	int                   n_samples, n_results, n_errors, n_short, n_long, n_settings;

	key_debounce_press_classifier i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Result side back-pressure
	always @(posedge clk) begin
		m_tready <= stalls_on ? ($urandom_range(99) >= 33) : 1'b1;
	end

	// Debounce and classify one sample, updating the predictor state
	function automatic key_state_t classify_sample(logic lvl, logic [TIME_IN_W-1:0] t,
			logic clr);
		logic                 was;
		logic [TIME_IN_W-1:0] held;
		key_state_t           r;
		if (clr) key_event = EV_IDLE;
		if (lvl != key_prev) begin
			key_prev = lvl;
			key_run  = RUN_W'(1);
		end else begin
			if (key_run < cfg_confirm && key_run < RUN_MAX) key_run = key_run + 1'b1;
			if (key_run >= cfg_confirm && lvl != key_level) begin
				was       = key_level;
				key_level = lvl;
				if (lvl) begin
					key_stamp = t;
					key_event = EV_IDLE;
				end else if (was) begin
					held = t - key_stamp;
					if (held < {16'b0, cfg_thr}) key_event = EV_SHORT;
				end
			end
			// still held: promote to long once the threshold is reached
			held = t - key_stamp;
			if (key_level && lvl && held >= {16'b0, cfg_thr}) key_event = EV_LONG;
		end
		r.level = key_level;
		r.ev    = key_event;
		return r;
	endfunction

	// Send one sample, wait for it to be taken, record its expected result
	task automatic send_sample(logic lvl, logic [TIME_IN_W-1:0] t, logic clr);
		logic took;
		if (stalls_on) begin
			while ($urandom_range(99) < 33) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tdata  <= {6'b0, clr, t, lvl};
		s_tvalid <= 1'b1;
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		key_state_q.push_back(classify_sample(lvl, t, clr));
		n_samples++;
	endtask

	// Stop sending and wait until every expected result has come out
	task automatic settle();
		s_tvalid <= 1'b0;
		while (key_state_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_LONG_THR) cfg_thr = val[THR_W-1:0];
		else cfg_confirm = val[CONF_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(logic [THR_W-1:0] thr, logic [CONF_W-1:0] conf);
		settle();
		write_reg(REG_LONG_THR, thr);
		write_reg(REG_CONFIRM, {12'b0, conf});
		n_settings++;
	endtask

	// Default registers: release with no press, short press, then clear
	task automatic test_default_short_press();
		send_sample(1'b0, 32'd0, 1'b0);
		send_sample(1'b1, 32'd10, 1'b0);
		send_sample(1'b1, 32'd20, 1'b0);
		send_sample(1'b1, 32'd30, 1'b0);
		send_sample(1'b0, 32'd40, 1'b0);
		send_sample(1'b0, 32'd50, 1'b0);
		send_sample(1'b0, 32'd60, 1'b0);
		send_sample(1'b0, 32'd70, 1'b1);
	endtask

	// Zero threshold and zero confirm: long on first confirmed sample, kept on release
	task automatic test_zero_settings_long();
		apply_setting(16'd0, 4'd0);
		send_sample(1'b1, 32'hFFFF_FFFF, 1'b0);
		send_sample(1'b1, 32'd5, 1'b0);
		send_sample(1'b0, 32'd6, 1'b0);
		send_sample(1'b0, 32'd7, 1'b0);
	endtask

	// Largest settings: bouncing key never confirms
	task automatic test_bounce_max_settings();
		apply_setting(16'hFFFF, 4'd15);
		send_sample(1'b1, 32'hAAAA_AAAA, 1'b1);
		send_sample(1'b0, 32'h5555_5555, 1'b0);
		send_sample(1'b1, 32'hAAAA_AAAA, 1'b0);
		send_sample(1'b0, 32'h5555_5555, 1'b1);
	endtask

	// Smallest settings: long just before the time wrap, clear, release across the wrap, short press
	task automatic test_unit_settings_wrap();
		apply_setting(16'd1, 4'd1);
		send_sample(1'b1, 32'hFFFF_FFFE, 1'b0);
		send_sample(1'b1, 32'hFFFF_FFFE, 1'b0);
		send_sample(1'b1, 32'hFFFF_FFFF, 1'b0);
		send_sample(1'b0, 32'd0, 1'b1);
		send_sample(1'b0, 32'd0, 1'b0);
		send_sample(1'b1, 32'd100, 1'b0);
		send_sample(1'b1, 32'd100, 1'b0);
		send_sample(1'b0, 32'd100, 1'b0);
		send_sample(1'b0, 32'd100, 1'b0);
	endtask

	// One key press: some bounce, a hold around the threshold, bounce, release
	task automatic press_episode();
		int          n;
		int unsigned span, step;
		n    = ((cfg_confirm < 2) ? 2 : cfg_confirm) + $urandom_range(0, 3);
		span = $urandom_range(1) ? cfg_thr + $urandom_range(0, cfg_thr)
			: $urandom_range(0, cfg_thr);
		step = span / n;
		repeat ($urandom_range(0, 2)) begin
			clk_ms += $urandom_range(0, 3);
			send_sample(1'($urandom_range(1)), clk_ms, $urandom_range(9) == 0);
		end
		repeat (n) begin
			clk_ms += step + $urandom_range(0, 1);
			send_sample(1'b1, clk_ms, $urandom_range(9) == 0);
		end
		repeat ($urandom_range(0, 2)) begin
			clk_ms += $urandom_range(0, 3);
			send_sample(1'($urandom_range(1)), clk_ms, $urandom_range(9) == 0);
		end
		repeat (((cfg_confirm < 2) ? 2 : cfg_confirm) + $urandom_range(0, 2)) begin
			clk_ms += $urandom_range(0, 5);
			send_sample(1'b0, clk_ms, $urandom_range(9) == 0);
		end
	endtask

	// Random setting, then press episodes mixed with raw noise
	task automatic random_phase(int n_items);
		logic [THR_W-1:0]  thr;
		logic [CONF_W-1:0] conf;
		int                goal;
		case ($urandom_range(3))
			0: thr = 16'd1;
			1: thr = 16'hFFFF;
			2: thr = THR_W'($urandom_range(2, 64));
			default: thr = THR_W'($urandom_range(1, 65535));
		endcase
		case ($urandom_range(4))
			0: conf = 4'd1;
			1: conf = 4'd15;
			default: conf = CONF_W'($urandom_range(1, 4));
		endcase
		apply_setting(thr, conf);
		clk_ms = $urandom;
		goal   = n_samples + n_items;
		while (n_samples < goal) begin
			if ($urandom_range(99) < 85) begin
				press_episode();
			end else begin
				repeat ($urandom_range(1, 3))
					send_sample(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
			end
		end
	endtask

	task automatic test_random_traffic();
		repeat (6) random_phase(100);
	endtask

	task automatic test_random_no_stalls();
		settle();
		stalls_on = 1'b0;
		repeat (2) random_phase(100);
		settle();
		stalls_on = 1'b1;
	endtask

	// Result checker; values are stable from the falling edge to the taking edge
	always @(negedge clk) begin
		key_state_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.level = m_tdata[0];
			got.ev    = m_tdata[2:1];
			n_results++;
			if (got.ev == EV_SHORT) n_short++;
			if (got.ev == EV_LONG) n_long++;
			if (key_state_q.size() == 0) begin
				$display("%0t result with none expected: level %0d event %0d",
					$time, got.level, got.ev);
				n_errors++;
			end else begin
				want = key_state_q.pop_front();
				if (got.level !== want.level) begin
					$display("%0t debounced_level mismatch: expected %0d actual %0d",
						$time, want.level, got.level);
					n_errors++;
				end
				if (got.ev !== want.ev) begin
					$display("%0t press_event mismatch: expected %0d actual %0d",
						$time, want.ev, got.ev);
					n_errors++;
				end
			end
		end
	end

	initial begin
		key_prev    = 1'b0;
		key_run     = '0;
		key_level   = 1'b0;
		key_stamp   = '0;
		key_event   = EV_IDLE;
		cfg_thr     = THR_RESET;
		cfg_confirm = CONFIRM_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_default_short_press();
		test_zero_settings_long();
		test_bounce_max_settings();
		test_unit_settings_wrap();
		test_random_traffic();
		test_random_no_stalls();
		settle();

		$display("Checked %0d samples and %0d results over %0d register settings,",
			n_samples, n_results, n_settings);
		$display("with %0d short-press and %0d long-press results seen.", n_short, n_long);
		if (n_errors == 0 && key_state_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("%0t timeout with %0d results outstanding", $time, key_state_q.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
